>>> rtl/ugm_pkg.sv
`timescale 1ns / 1ps
package ugm_pkg;

  // defaults for the top level parameters
  localparam int DEF_GRID_COLUMNS  = 16;
  localparam int DEF_GRID_ROWS     = 16;
  localparam int DEF_MAX_OBJECTS   = 64;
  localparam int DEF_CELL_CAPACITY = 64;
  localparam int DEF_MAX_SPAN      = 4;

  // fixed field widths
  localparam int COORD_W     = 12;
  localparam int OBJ_PORT_W  = 6;
  localparam int JOB_COORD_W = 6;
  localparam int BIT_CNT_W   = $clog2(COORD_W + 1);
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 1'd1;
  localparam logic [COORD_W-1:0]   CELL_SIZE_RESET = 12'd64;

  typedef enum logic [1:0] {
    EV_REMOVED = 2'd0,
    EV_ADDED   = 2'd1,
    EV_DROPPED = 2'd2,
    EV_NONE    = 2'd3
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [3:0] cx;
    logic [3:0] cy;
    logic [5:0] slot;
    logic [5:0] moved;
    logic       mv;
  } ev_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic [OBJ_PORT_W-1:0]  obj;
    logic [JOB_COORD_W-1:0] x0;
    logic [JOB_COORD_W-1:0] x1;
    logic [JOB_COORD_W-1:0] y0;
    logic [JOB_COORD_W-1:0] y1;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_CNT,
    B_RRD,
    B_RCHK,
    B_RFILL,
    B_RMOV,
    B_REMIT,
    B_FXCNT,
    B_FXRD,
    B_FXCHK,
    B_ACHK,
    B_AFILL,
    B_AEMIT,
    B_ANEXT,
    B_WBCNT,
    B_NOCH,
    B_FIN
  } back_state_t;

  function automatic int clog2g(input int v);
    return (v > 1) ? $clog2(v) : 1;
  endfunction

endpackage

>>> rtl/uniform_grid_membership_update.sv
`timescale 1ns / 1ps
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    object id, box left/top/right/bottom
// out      out  out_valid / out_stall  one event per change, drop or no-change
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data (cell width, height)
//
// front: takes no new item until the last is pushed (12-step restoring division
//   of the four box edges, then a push into a two-entry queue)
// back: reads the object's cell list, keeps each still-covered cell, removes the
//   rest (a relocation then scans the moved object's list), then walks the covered
//   cells, adding or dropping each one not already held; the slot and list
//   memories each have one read port and one write port
// reset: synchronous, active low; fill and count stores use per-entry valid bits,
//   so no clearing pass is needed
// a stalled output holds its event; the back waits, the front keeps dividing
module uniform_grid_membership_update
  import ugm_pkg::*;
#(
  parameter int GRID_COLUMNS  = DEF_GRID_COLUMNS,
  parameter int GRID_ROWS     = DEF_GRID_ROWS,
  parameter int MAX_OBJECTS   = DEF_MAX_OBJECTS,
  parameter int CELL_CAPACITY = DEF_CELL_CAPACITY,
  parameter int MAX_SPAN      = DEF_MAX_SPAN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OBJ_PORT_W-1:0] in_object_id,
  input  logic [COORD_W-1:0]    in_box_left,
  input  logic [COORD_W-1:0]    in_box_top,
  input  logic [COORD_W-1:0]    in_box_right,
  input  logic [COORD_W-1:0]    in_box_bottom,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_kind,
  output logic [3:0]            out_cell_x,
  output logic [3:0]            out_cell_y,
  output logic [5:0]            out_slot_index,
  output logic [5:0]            out_moved_object,
  output logic                  out_moved_valid,
  output logic                  out_last_event,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data
);

  // cell size registers
  logic [COORD_W-1:0] cell_width_r, cell_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= CELL_SIZE_RESET;
      cell_height_r <= CELL_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CELL_WIDTH:  cell_width_r  <= cfg_data;
        CFG_CELL_HEIGHT: cell_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: divide and clamp into a cell range
  logic f_job_valid, q_full, q_empty, b_pop;
  job_t f_job, q_job;

  ugm_front #(
    .COLS(GRID_COLUMNS), .ROWS(GRID_ROWS), .SPAN(MAX_SPAN)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_object_id(in_object_id),
    .in_box_left(in_box_left), .in_box_top(in_box_top),
    .in_box_right(in_box_right), .in_box_bottom(in_box_bottom),
    .cell_width(cell_width_r), .cell_height(cell_height_r),
    .job_valid(f_job_valid), .job_ready(!q_full), .job(f_job)
  );

  // short queue decouples division from the membership walk
  ugm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(f_job_valid && !q_full), .din(f_job), .full(q_full),
    .pop(b_pop), .dout(q_job), .empty(q_empty)
  );

  // back: removals by swap-with-last, then additions, one event per change
  ugm_back #(
    .COLS(GRID_COLUMNS), .ROWS(GRID_ROWS), .MAX_OBJ(MAX_OBJECTS),
    .CAP(CELL_CAPACITY), .SPAN(MAX_SPAN)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(!q_empty), .job_pop(b_pop), .job(q_job),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_kind(out_event_kind), .out_cell_x(out_cell_x),
    .out_cell_y(out_cell_y), .out_slot_index(out_slot_index),
    .out_moved_object(out_moved_object), .out_moved_valid(out_moved_valid),
    .out_last_event(out_last_event)
  );

  // front is busy right after taking an item
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front accepted back-to-back items");

  // a no-change event always stands alone
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == 2'(EV_NONE) |-> out_last_event)
    else $error("no-change event not marked last");

  // only removals carry a relocation
  a_moved_removal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != 2'(EV_REMOVED) |-> !out_moved_valid)
    else $error("relocation on a non-removal event");

  // queue never pops while empty
  a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
    b_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

>>> rtl/ugm_ram.sv
`timescale 1ns / 1ps
module ugm_ram
  import ugm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [clog2g(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [clog2g(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ugm_queue.sv
`timescale 1ns / 1ps
module ugm_queue
  import ugm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  localparam int PW = clog2g(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          ent_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full  = (int'(cnt_r) == DEPTH);
  assign empty = (cnt_r == '0);
  assign dout  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (int'(wp_r) == DEPTH - 1) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (int'(rp_r) == DEPTH - 1) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ugm_front.sv
`timescale 1ns / 1ps
module ugm_front
  import ugm_pkg::*;
#(
  parameter int COLS = DEF_GRID_COLUMNS,
  parameter int ROWS = DEF_GRID_ROWS,
  parameter int SPAN = DEF_MAX_SPAN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OBJ_PORT_W-1:0] in_object_id,
  input  logic [COORD_W-1:0]    in_box_left,
  input  logic [COORD_W-1:0]    in_box_top,
  input  logic [COORD_W-1:0]    in_box_right,
  input  logic [COORD_W-1:0]    in_box_bottom,
  input  logic [COORD_W-1:0]    cell_width,
  input  logic [COORD_W-1:0]    cell_height,
  output logic                  job_valid,
  input  logic                  job_ready,
  output job_t                  job
);

  front_state_t st_r, st_nxt;
  // four restoring divider lanes: left, right, top, bottom
  logic [COORD_W-1:0]    dvd_r [4];
  logic [COORD_W-1:0]    dvd_nxt [4];
  logic [COORD_W-1:0]    rem_r [4];
  logic [COORD_W-1:0]    rem_nxt [4];
  logic [BIT_CNT_W-1:0]  bit_r, bit_nxt;
  logic [COORD_W-1:0]    dx_r, dx_nxt, dy_r, dy_nxt;
  logic [OBJ_PORT_W-1:0] obj_r, obj_nxt;

  function automatic logic [COORD_W-1:0] clamp_idx(input logic [COORD_W-1:0] v,
                                                   input int cells);
    logic [COORD_W-1:0] top_idx;
    top_idx = COORD_W'(cells - 1);
    return (v > top_idx) ? top_idx : v;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_span(input logic [COORD_W-1:0] lo,
                                                    input logic [COORD_W-1:0] hi);
    logic [COORD_W:0] lim;
    lim = {1'b0, lo} + (COORD_W + 1)'(SPAN - 1);
    return ({1'b0, hi} > lim) ? lim[COORD_W-1:0] : hi;
  endfunction

  logic [COORD_W-1:0] px0, px1, py0, py1;

  always_comb begin
    px0 = clamp_idx(dvd_r[0], COLS);
    px1 = clamp_span(px0, clamp_idx(dvd_r[1], COLS));
    py0 = clamp_idx(dvd_r[2], ROWS);
    py1 = clamp_span(py0, clamp_idx(dvd_r[3], ROWS));
    job.obj = obj_r;
    job.x0  = px0[JOB_COORD_W-1:0];
    job.x1  = px1[JOB_COORD_W-1:0];
    job.y0  = py0[JOB_COORD_W-1:0];
    job.y1  = py1[JOB_COORD_W-1:0];
  end

  assign in_stall  = (st_r != F_IDLE);
  assign job_valid = (st_r == F_PUSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    obj_r <= obj_nxt;
  end

  always_comb begin
    logic [COORD_W:0]   trial;
    logic [COORD_W-1:0] d;
    st_nxt  = st_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    bit_nxt = bit_r;
    dx_nxt  = dx_r;
    dy_nxt  = dy_r;
    obj_nxt = obj_r;
    trial   = '0;
    d       = '0;
    unique case (st_r)
      F_IDLE: begin
        if (in_valid) begin
          // order edges so that lane 0/2 holds the low edge
          dvd_nxt[0] = (in_box_right < in_box_left) ? in_box_right : in_box_left;
          dvd_nxt[1] = (in_box_right < in_box_left) ? in_box_left : in_box_right;
          dvd_nxt[2] = (in_box_bottom < in_box_top) ? in_box_bottom : in_box_top;
          dvd_nxt[3] = (in_box_bottom < in_box_top) ? in_box_top : in_box_bottom;
          for (int l = 0; l < 4; l++) begin
            rem_nxt[l] = '0;
          end
          // zero cell size acts as one
          dx_nxt  = (cell_width == '0) ? COORD_W'(1) : cell_width;
          dy_nxt  = (cell_height == '0) ? COORD_W'(1) : cell_height;
          obj_nxt = in_object_id;
          bit_nxt = '0;
          st_nxt  = F_DIV;
        end
      end
      F_DIV: begin
        for (int l = 0; l < 4; l++) begin
          d     = (l < 2) ? dx_r : dy_r;
          trial = {rem_r[l], dvd_r[l][COORD_W-1]};
          if (trial >= {1'b0, d}) begin
            trial      = trial - {1'b0, d};
            dvd_nxt[l] = {dvd_r[l][COORD_W-2:0], 1'b1};
          end else begin
            dvd_nxt[l] = {dvd_r[l][COORD_W-2:0], 1'b0};
          end
          rem_nxt[l] = trial[COORD_W-1:0];
        end
        bit_nxt = bit_r + 1'b1;
        if (int'(bit_r) == COORD_W - 1) begin
          st_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (job_ready) begin
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

endmodule

>>> rtl/ugm_back.sv
`timescale 1ns / 1ps
module ugm_back
  import ugm_pkg::*;
#(
  parameter int COLS    = DEF_GRID_COLUMNS,
  parameter int ROWS    = DEF_GRID_ROWS,
  parameter int MAX_OBJ = DEF_MAX_OBJECTS,
  parameter int CAP     = DEF_CELL_CAPACITY,
  parameter int SPAN    = DEF_MAX_SPAN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  output logic       job_pop,
  input  job_t       job,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic [3:0] out_cell_x,
  output logic [3:0] out_cell_y,
  output logic [5:0] out_slot_index,
  output logic [5:0] out_moved_object,
  output logic       out_moved_valid,
  output logic       out_last_event
);

  localparam int L      = SPAN * SPAN;
  localparam int NCELL  = COLS * ROWS;
  localparam int CELL_W = clog2g(NCELL);
  localparam int COL_W  = clog2g(COLS);
  localparam int ROW_W  = clog2g(ROWS);
  localparam int OBJ_W  = clog2g(MAX_OBJ);
  localparam int SLOT_W = clog2g(CAP);
  localparam int FILL_W = $clog2(CAP + 1);
  localparam int LI_W   = clog2g(L);
  localparam int CNT_W  = $clog2(L + 1);
  localparam int SP_W   = clog2g(SPAN);
  localparam int LA_W   = clog2g(MAX_OBJ * L);
  localparam int SA_W   = clog2g(NCELL * CAP);
  localparam int ENT_W  = COL_W + ROW_W + SLOT_W;

  function automatic logic [CELL_W-1:0] cell_of(input logic [COL_W-1:0] cx,
                                                input logic [ROW_W-1:0] cy);
    return CELL_W'(int'(cy) * COLS + int'(cx));
  endfunction

  function automatic logic [SA_W-1:0] slot_addr(input logic [CELL_W-1:0] c,
                                                input logic [SLOT_W-1:0] s);
    return SA_W'(int'(c) * CAP + int'(s));
  endfunction

  function automatic logic [LA_W-1:0] list_addr(input logic [OBJ_W-1:0] o,
                                                input logic [CNT_W-1:0] idx);
    return LA_W'(int'(o) * L + int'(idx));
  endfunction

  // memories
  logic                  fill_we;
  logic [CELL_W-1:0]     fill_waddr, fill_raddr;
  logic [FILL_W-1:0]     fill_wdata, fill_q;
  logic                  slot_we;
  logic [SA_W-1:0]       slot_waddr, slot_raddr;
  logic [OBJ_W-1:0]      slot_wdata, slot_q;
  logic                  cnt_we;
  logic [OBJ_W-1:0]      cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]      cnt_wdata, cnt_q;
  logic                  list_we;
  logic [LA_W-1:0]       list_waddr, list_raddr;
  logic [ENT_W-1:0]      list_wdata, list_q;

  ugm_ram #(.WIDTH(FILL_W), .DEPTH(NCELL)) u_fill_ram (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_q)
  );
  ugm_ram #(.WIDTH(OBJ_W), .DEPTH(NCELL * CAP)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_q)
  );
  ugm_ram #(.WIDTH(CNT_W), .DEPTH(MAX_OBJ)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_q)
  );
  ugm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_OBJ * L)) u_list_ram (
    .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .raddr(list_raddr), .rdata(list_q)
  );

  back_state_t       st_r, st_nxt;
  logic [NCELL-1:0]  fill_vld_r, fill_vld_nxt;
  logic [MAX_OBJ-1:0] cnt_vld_r, cnt_vld_nxt;
  logic [OBJ_W-1:0]  obj_r, obj_nxt, mobj_r, mobj_nxt;
  logic [COL_W-1:0]  x0_r, x0_nxt, x1_r, x1_nxt, ecx_r, ecx_nxt;
  logic [ROW_W-1:0]  y0_r, y0_nxt, y1_r, y1_nxt, ecy_r, ecy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, i_r, i_nxt, k_r, k_nxt, mc_r, mc_nxt, j_r, j_nxt;
  logic [L-1:0]      mask_r, mask_nxt;
  logic [SLOT_W-1:0] es_r, es_nxt;
  logic [OBJ_W-1:0]  ev_mov_r, ev_mov_nxt;
  logic              ev_mv_r, ev_mv_nxt, fix_r, fix_nxt, any_ev_r, any_ev_nxt;
  ev_kind_t          ev_kind_r, ev_kind_nxt;
  logic [SP_W-1:0]   ax_r, ax_nxt, ay_r, ay_nxt;
  ev_t               pend_r, pend_nxt, out_r, out_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_r.kind;
  assign out_cell_x       = out_r.cx;
  assign out_cell_y       = out_r.cy;
  assign out_slot_index   = out_r.slot;
  assign out_moved_object = out_r.moved;
  assign out_moved_valid  = out_r.mv;
  assign out_last_event   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= B_IDLE;
      fill_vld_r   <= '0;
      cnt_vld_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      fill_vld_r   <= fill_vld_nxt;
      cnt_vld_r    <= cnt_vld_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obj_r      <= obj_nxt;
    mobj_r     <= mobj_nxt;
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    ecx_r      <= ecx_nxt;
    ecy_r      <= ecy_nxt;
    cnt_r      <= cnt_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    mc_r       <= mc_nxt;
    j_r        <= j_nxt;
    mask_r     <= mask_nxt;
    es_r       <= es_nxt;
    ev_mov_r   <= ev_mov_nxt;
    ev_mv_r    <= ev_mv_nxt;
    fix_r      <= fix_nxt;
    any_ev_r   <= any_ev_nxt;
    ev_kind_r  <= ev_kind_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  logic [CELL_W-1:0] cur_cell;
  logic              out_free, can_emit;

  assign cur_cell = cell_of(ecx_r, ecy_r);
  assign out_free = !out_valid_r || !out_stall;
  assign can_emit = !pend_valid_r || out_free;

  always_comb begin
    logic              emit, flush;
    ev_t               ev;
    logic [COL_W-1:0]  qx, mx;
    logic [ROW_W-1:0]  qy, my;
    logic [SLOT_W-1:0] qs;
    logic [FILL_W-1:0] f, last;
    logic [CNT_W-1:0]  c;
    logic [LI_W-1:0]   mi;

    st_nxt         = st_r;
    fill_vld_nxt   = fill_vld_r;
    cnt_vld_nxt    = cnt_vld_r;
    obj_nxt        = obj_r;
    mobj_nxt       = mobj_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    y0_nxt         = y0_r;
    y1_nxt         = y1_r;
    ecx_nxt        = ecx_r;
    ecy_nxt        = ecy_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    mc_nxt         = mc_r;
    j_nxt          = j_r;
    mask_nxt       = mask_r;
    es_nxt         = es_r;
    ev_mov_nxt     = ev_mov_r;
    ev_mv_nxt      = ev_mv_r;
    fix_nxt        = fix_r;
    any_ev_nxt     = any_ev_r;
    ev_kind_nxt    = ev_kind_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    out_last_nxt   = out_last_r;

    job_pop    = 1'b0;
    fill_we    = 1'b0;
    fill_waddr = cur_cell;
    fill_wdata = '0;
    fill_raddr = cur_cell;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    slot_raddr = '0;
    cnt_we     = 1'b0;
    cnt_waddr  = obj_r;
    cnt_wdata  = k_r;
    cnt_raddr  = obj_r;
    list_we    = 1'b0;
    list_waddr = '0;
    list_wdata = list_q;
    list_raddr = '0;

    emit  = 1'b0;
    flush = 1'b0;
    ev    = '{kind: ev_kind_r, cx: 4'(ecx_r), cy: 4'(ecy_r), slot: 6'(es_r),
              moved: '0, mv: 1'b0};
    qx    = list_q[ENT_W-1 -: COL_W];
    qy    = list_q[SLOT_W +: ROW_W];
    qs    = list_q[SLOT_W-1:0];
    // stored cell beyond the grid maps to cell zero
    mx    = ((int'(qx) >= COLS) || (int'(qy) >= ROWS)) ? '0 : qx;
    my    = ((int'(qx) >= COLS) || (int'(qy) >= ROWS)) ? '0 : qy;
    f     = fill_vld_r[cur_cell] ? fill_q : '0;
    last  = '0;
    c     = '0;
    mi    = '0;

    unique case (st_r)
      B_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          obj_nxt    = OBJ_W'(job.obj);
          x0_nxt     = COL_W'(job.x0);
          x1_nxt     = COL_W'(job.x1);
          y0_nxt     = ROW_W'(job.y0);
          y1_nxt     = ROW_W'(job.y1);
          any_ev_nxt = 1'b0;
          cnt_raddr  = OBJ_W'(job.obj);
          if (int'(job.obj) >= MAX_OBJ) begin
            st_nxt = B_NOCH;
          end else begin
            st_nxt = B_CNT;
          end
        end
      end
      B_CNT: begin
        c        = cnt_vld_r[obj_r] ? cnt_q : '0;
        cnt_nxt  = (int'(c) > L) ? CNT_W'(L) : c;
        i_nxt    = '0;
        k_nxt    = '0;
        mask_nxt = '0;
        st_nxt   = B_RRD;
      end
      B_RRD: begin
        if (i_r < cnt_r) begin
          list_raddr = list_addr(obj_r, i_r);
          st_nxt     = B_RCHK;
        end else begin
          ax_nxt = '0;
          ay_nxt = '0;
          st_nxt = B_ACHK;
        end
      end
      B_RCHK: begin
        i_nxt = i_r + 1'b1;
        if (mx >= x0_r && mx <= x1_r && my >= y0_r && my <= y1_r) begin
          // still covered: keep, compacting the list in place
          list_we      = 1'b1;
          list_waddr   = list_addr(obj_r, k_r);
          list_wdata   = list_q;
          k_nxt        = k_r + 1'b1;
          mi           = LI_W'(int'(mx - x0_r) * SPAN + int'(my - y0_r));
          mask_nxt[mi] = 1'b1;
          st_nxt       = B_RRD;
        end else begin
          ecx_nxt    = mx;
          ecy_nxt    = my;
          es_nxt     = qs;
          fill_raddr = cell_of(mx, my);
          st_nxt     = B_RFILL;
        end
      end
      B_RFILL: begin
        ev_mv_nxt   = 1'b0;
        ev_mov_nxt  = '0;
        fix_nxt     = 1'b0;
        ev_kind_nxt = EV_REMOVED;
        if (int'(f) > CAP) begin
          f = FILL_W'(CAP);
        end
        st_nxt = B_REMIT;
        if (f != '0 && FILL_W'(es_r) < f) begin
          last                   = f - 1'b1;
          fill_we                = 1'b1;
          fill_wdata             = last;
          fill_vld_nxt[cur_cell] = 1'b1;
          if (FILL_W'(es_r) != last) begin
            // swap with last: fetch the tail occupant
            slot_raddr = slot_addr(cur_cell, SLOT_W'(last));
            st_nxt     = B_RMOV;
          end
        end
      end
      B_RMOV: begin
        slot_we    = 1'b1;
        slot_waddr = slot_addr(cur_cell, es_r);
        slot_wdata = slot_q;
        ev_mov_nxt = slot_q;
        ev_mv_nxt  = 1'b1;
        mobj_nxt   = slot_q;
        fix_nxt    = (int'(slot_q) < MAX_OBJ);
        st_nxt     = B_REMIT;
      end
      B_REMIT: begin
        if (can_emit) begin
          emit       = 1'b1;
          ev.moved   = 6'(ev_mov_r);
          ev.mv      = ev_mv_r;
          any_ev_nxt = 1'b1;
          if (fix_r) begin
            cnt_raddr = mobj_r;
            st_nxt    = B_FXCNT;
          end else begin
            st_nxt = B_RRD;
          end
        end
      end
      B_FXCNT: begin
        c      = cnt_vld_r[mobj_r] ? cnt_q : '0;
        mc_nxt = (int'(c) > L) ? CNT_W'(L) : c;
        j_nxt  = '0;
        st_nxt = B_FXRD;
      end
      B_FXRD: begin
        if (j_r < mc_r) begin
          list_raddr = list_addr(mobj_r, j_r);
          st_nxt     = B_FXCHK;
        end else begin
          st_nxt = B_RRD;
        end
      end
      B_FXCHK: begin
        if (qx == ecx_r && qy == ecy_r) begin
          // back-pointer of the relocated object now names the freed slot
          list_we    = 1'b1;
          list_waddr = list_addr(mobj_r, j_r);
          list_wdata = {qx, qy, es_r};
          st_nxt     = B_RRD;
        end else begin
          j_nxt  = j_r + 1'b1;
          st_nxt = B_FXRD;
        end
      end
      B_ACHK: begin
        ecx_nxt = x0_r + COL_W'(ax_r);
        ecy_nxt = y0_r + ROW_W'(ay_r);
        mi      = LI_W'(int'(ax_r) * SPAN + int'(ay_r));
        if (mask_r[mi]) begin
          st_nxt = B_ANEXT;
        end else begin
          fill_raddr = cell_of(x0_r + COL_W'(ax_r), y0_r + ROW_W'(ay_r));
          st_nxt     = B_AFILL;
        end
      end
      B_AFILL: begin
        if (int'(f) >= CAP || int'(k_r) >= L) begin
          ev_kind_nxt = EV_DROPPED;
          es_nxt      = '0;
        end else begin
          slot_we                = 1'b1;
          slot_waddr             = slot_addr(cur_cell, SLOT_W'(f));
          slot_wdata             = obj_r;
          fill_we                = 1'b1;
          fill_wdata             = f + 1'b1;
          fill_vld_nxt[cur_cell] = 1'b1;
          list_we                = 1'b1;
          list_waddr             = list_addr(obj_r, k_r);
          list_wdata             = {ecx_r, ecy_r, SLOT_W'(f)};
          k_nxt                  = k_r + 1'b1;
          ev_kind_nxt            = EV_ADDED;
          es_nxt                 = SLOT_W'(f);
        end
        st_nxt = B_AEMIT;
      end
      B_AEMIT: begin
        if (can_emit) begin
          emit       = 1'b1;
          any_ev_nxt = 1'b1;
          st_nxt     = B_ANEXT;
        end
      end
      B_ANEXT: begin
        st_nxt = B_ACHK;
        if (int'(ay_r) == int'(y1_r - y0_r)) begin
          ay_nxt = '0;
          if (int'(ax_r) == int'(x1_r - x0_r)) begin
            st_nxt = B_WBCNT;
          end else begin
            ax_nxt = ax_r + 1'b1;
          end
        end else begin
          ay_nxt = ay_r + 1'b1;
        end
      end
      B_WBCNT: begin
        cnt_we                = 1'b1;
        cnt_vld_nxt[obj_r]    = 1'b1;
        st_nxt                = any_ev_r ? B_FIN : B_NOCH;
      end
      B_NOCH: begin
        if (can_emit) begin
          emit       = 1'b1;
          ev         = '{kind: EV_NONE, cx: 4'(x0_r), cy: 4'(y0_r), slot: '0,
                         moved: '0, mv: 1'b0};
          any_ev_nxt = 1'b1;
          st_nxt     = B_FIN;
        end
      end
      B_FIN: begin
        if (out_free) begin
          flush  = 1'b1;
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase

    // one event held back so the final one can be marked
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      if (pend_valid_r) begin
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt       = ev;
      pend_valid_nxt = 1'b1;
    end
    if (flush) begin
      out_nxt        = pend_r;
      out_last_nxt   = 1'b1;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

endmodule
